>>> hw/rtl/assert_macros.svh
// Assertion macros for the stack RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge out of reset.
`define SWS_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SWS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the stack with duplicate and rotate.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Request kinds; code seven is unused and handled like a size query
    typedef enum logic [2:0] {
        KIND_PUSH = 3'd0,
        KIND_POP  = 3'd1,
        KIND_PEEK = 3'd2,
        KIND_DUP  = 3'd3,
        KIND_ROTL = 3'd4,
        KIND_ROTR = 3'd5,
        KIND_SIZE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BOUNDS = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ROT_HOLD,
        S_ROT_MOVE,
        S_ROT_END
    } state_t;

    // Result strobe from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_t;

endpackage

>>> hw/rtl/stack_with_dup_and_rotate.sv
// ----------------------------------------------------------------------------
// stack_with_dup_and_rotate
// LIFO word stack with push, pop, peek, duplicate, bottom rotates and size.
// ----------------------------------------------------------------------------
// Push, size and error results form as the request is taken; pop, peek, duplicate
// answer from READ. Rotate by n walks HOLD, MOVE and END, one memory read and write
// per entry for n >= 2. Push and size: 1 word per cycle unless stalled.
// A request is taken only in IDLE and when the output register is empty or draining.
// Reset clears the fill count and the sequencer; memory contents are kept.

module stack_with_dup_and_rotate #(
    parameter int DEPTH     = sws_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sws_pkg::WORD_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int ADDR_W   = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           kind,
    input  logic [WORD_BITS-1:0] push_word,
    input  logic [CNT_W-1:0]     rotate_count,
    // response channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [WORD_BITS-1:0] read_word,
    output logic [1:0]           status,
    output logic [CNT_W-1:0]     fill_level,
    output logic                 is_empty
);

    import sws_pkg::*;

    res_t                 res;
    logic [WORD_BITS-1:0] res_word;
    logic [CNT_W-1:0]     res_fill;
    logic                 out_free;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic                 rsp_valid_reg;
    logic [WORD_BITS-1:0] word_reg;
    status_t              status_reg;
    logic [CNT_W-1:0]     fill_out_reg;

    sws_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sws_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .push_word    (push_word),
        .rotate_count (rotate_count),
        .out_free     (out_free),
        .res          (res),
        .res_word     (res_word),
        .res_fill     (res_fill),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // Output register has room when empty or handing off its word this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Hold the response valid until the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Capture the response payload
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            word_reg     <= res_word;
            status_reg   <= res.status;
            fill_out_reg <= res_fill;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_word  = word_reg;
    assign status     = 2'(status_reg);
    assign fill_level = fill_out_reg;
    assign is_empty   = (fill_out_reg == '0);

endmodule

>>> hw/rtl/sws_ram.sv
// ----------------------------------------------------------------------------
// sws_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
    parameter int DEPTH     = sws_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sws_pkg::WORD_BITS_DEF,
    localparam int ADDR_W   = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl
// Request sequencer: fill counter, memory read-modify-write and rotate walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sws_ctrl #(
    parameter int DEPTH     = sws_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sws_pkg::WORD_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int ADDR_W   = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           kind,
    input  logic [WORD_BITS-1:0] push_word,
    input  logic [CNT_W-1:0]     rotate_count,
    // room in the output register this cycle
    input  logic                 out_free,
    // result to the output register
    output sws_pkg::res_t        res,
    output logic [WORD_BITS-1:0] res_word,
    output logic [CNT_W-1:0]     res_fill,
    // memory port
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [WORD_BITS-1:0] rd_data
);

    import sws_pkg::*;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     moves_reg, moves_next;
    logic [ADDR_W-1:0]    src_reg, src_next;
    logic [WORD_BITS-1:0] hold_reg, hold_next;

    kind_t                kind_in;
    logic                 take;
    logic                 now_empty;
    logic                 now_full;
    logic                 bad_count;
    logic                 rot_left;
    logic [CNT_W-1:0]     fill_dec;
    logic [CNT_W-1:0]     cnt_in_dec;
    logic [CNT_W-1:0]     cnt_reg_dec;
    logic [ADDR_W-1:0]    top_addr;
    logic [ADDR_W-1:0]    free_addr;
    logic [ADDR_W-1:0]    src_up;
    logic [ADDR_W-1:0]    src_dn;

    // Decode the incoming request and the current fill
    assign kind_in     = kind_t'(kind);
    assign req_stall   = !((state_reg == S_IDLE) && out_free);
    assign take        = req_valid && !req_stall;
    assign now_empty   = (fill_reg == '0);
    assign now_full    = (fill_reg == CNT_W'(DEPTH));
    assign bad_count   = (rotate_count == '0) || (rotate_count > fill_reg);
    assign rot_left    = (kind_reg == KIND_ROTL);
    assign fill_dec    = fill_reg - 1'b1;
    assign cnt_in_dec  = rotate_count - 1'b1;
    assign cnt_reg_dec = cnt_reg - 1'b1;
    assign top_addr    = fill_dec[ADDR_W-1:0];
    assign free_addr   = fill_reg[ADDR_W-1:0];
    assign src_up      = src_reg + 1'b1;
    assign src_dn      = src_reg - 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (kind_in)
                        KIND_POP, KIND_PEEK:
                        begin
                            if (!now_empty)
                            begin
                                state_next = S_READ;
                            end
                        end
                        KIND_DUP:
                        begin
                            if (!now_empty && !now_full)
                            begin
                                state_next = S_READ;
                            end
                        end
                        KIND_ROTL, KIND_ROTR:
                        begin
                            if (!bad_count)
                            begin
                                state_next = S_ROT_HOLD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_ROT_HOLD:
            begin
                state_next = (moves_reg == '0) ? S_IDLE : S_ROT_MOVE;
            end
            S_ROT_MOVE:
            begin
                if (moves_reg == CNT_W'(1))
                begin
                    state_next = S_ROT_END;
                end
            end
            S_ROT_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory accesses, counters and result
    always_comb
    begin
        kind_next  = kind_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        moves_next = moves_reg;
        src_next   = src_reg;
        hold_next  = hold_reg;
        wr_en      = 1'b0;
        wr_addr    = free_addr;
        wr_data    = push_word;
        rd_en      = 1'b0;
        rd_addr    = top_addr;
        res.valid  = 1'b0;
        res.status = STAT_OK;
        res_word   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    kind_next = kind_in;
                    unique case (kind_in)
                        KIND_PUSH:
                        begin
                            res.valid = 1'b1;
                            if (now_full)
                            begin
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (now_empty)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        KIND_DUP:
                        begin
                            if (now_empty)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_EMPTY;
                            end
                            else if (now_full)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        KIND_ROTL, KIND_ROTR:
                        begin
                            if (bad_count)
                            begin
                                res.valid  = 1'b1;
                                res.status = STAT_BOUNDS;
                            end
                            else
                            begin
                                // fetch the entry that wraps around
                                rd_en      = 1'b1;
                                rd_addr    = (kind_in == KIND_ROTL) ? '0
                                                                    : cnt_in_dec[ADDR_W-1:0];
                                src_next   = rd_addr;
                                cnt_next   = rotate_count;
                                moves_next = cnt_in_dec;
                            end
                        end
                        default:
                        begin
                            res.valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res.valid = 1'b1;
                unique case (kind_reg)
                    KIND_POP:
                    begin
                        res_word  = rd_data;
                        fill_next = fill_dec;
                    end
                    KIND_PEEK:
                    begin
                        res_word = rd_data;
                    end
                    default:
                    begin
                        // duplicate: copy the top word one place up
                        wr_en     = 1'b1;
                        wr_data   = rd_data;
                        fill_next = fill_reg + 1'b1;
                    end
                endcase
            end
            S_ROT_HOLD:
            begin
                hold_next = rd_data;
                if (moves_reg == '0)
                begin
                    res.valid = 1'b1;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rot_left ? src_up : src_dn;
                    src_next = rd_addr;
                end
            end
            S_ROT_MOVE:
            begin
                // shift one entry toward the wrap slot's old place
                wr_en      = 1'b1;
                wr_addr    = rot_left ? src_dn : src_up;
                wr_data    = rd_data;
                moves_next = moves_reg - 1'b1;
                if (moves_reg != CNT_W'(1))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rot_left ? src_up : src_dn;
                    src_next = rd_addr;
                end
            end
            S_ROT_END:
            begin
                wr_en     = 1'b1;
                wr_addr   = rot_left ? cnt_reg_dec[ADDR_W-1:0] : '0;
                wr_data   = hold_reg;
                res.valid = 1'b1;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase

        res_fill = fill_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        cnt_reg   <= cnt_next;
        moves_reg <= moves_next;
        src_reg   <= src_next;
        hold_reg  <= hold_next;
    end

    `SWS_ASSERT(a_fill_bound, fill_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SWS_ASSERT(a_no_rw_clash, !(rd_en && wr_en && (rd_addr == wr_addr)), "read and write same entry")
    `SWS_ASSERT_IMPL(a_res_room, res.valid, out_free, "result raised with output register busy")
    `SWS_ASSERT_NEXT(a_walk_keeps_fill, state_reg == S_ROT_MOVE, $stable(fill_reg), "fill moved during rotate")

endmodule
